/* src/hermite_newton_interpolator_top_defines.svh */
`ifndef HERMITE_NEWTON_INTERPOLATOR_TOP_DEFINES_SVH
`define HERMITE_NEWTON_INTERPOLATOR_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define HNINT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define HNINT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* src/hnint_pkg.sv */
`timescale 1ns / 1ps

package hnint_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int DIVD_W = 80;
  localparam int STEP_W = $clog2(DIVD_W);

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_EVAL = 2'd2;

  localparam logic [1:0] KIND_COEF = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT_RG, OP_INIT_RY, OP_INIT_WR, OP_ZERO_COEF,
    OP_LV_RD0, OP_LV_RD1, OP_LV_RD2, OP_LV_PREP, OP_LV_START, OP_LV_WR,
    OP_EM_RD, OP_EM_PUSH, OP_EV_TOP, OP_EV_LD, OP_EV_RD, OP_EV_D, OP_EV_M1,
    OP_EV_M2, OP_EV_M3, OP_EV_ADD, OP_EV_FM, OP_EV_SUM, OP_PUSH_VAL,
    OP_PUSH_VZERO, OP_PUSH_FULL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       take;
    logic       first;
    logic       last;
    logic       nz;
    logic [3:0] index;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [63:0] fact(input logic [7:0] k);
    logic [63:0] f;
    case (k)
      8'd0: f = 64'd1;
      8'd1: f = 64'd1;
      8'd2: f = 64'd2;
      8'd3: f = 64'd6;
      8'd4: f = 64'd24;
      8'd5: f = 64'd120;
      8'd6: f = 64'd720;
      8'd7: f = 64'd5040;
      8'd8: f = 64'd40320;
      8'd9: f = 64'd362880;
      8'd10: f = 64'd3628800;
      8'd11: f = 64'd39916800;
      8'd12: f = 64'd479001600;
      8'd13: f = 64'd6227020800;
      8'd14: f = 64'd87178291200;
      8'd15: f = 64'd1307674368000;
      8'd16: f = 64'd20922789888000;
      8'd17: f = 64'd355687428096000;
      8'd18: f = 64'd6402373705728000;
      8'd19: f = 64'd121645100408832000;
      8'd20: f = 64'd2432902008176640000;
      default: f = 64'd0;
    endcase
    return f;
  endfunction

  function automatic logic [63:0] from_mag(input logic [64:0] mag, input logic neg);
    logic [63:0] r;
    if (neg) begin
      if (mag >= 65'h0_8000_0000_0000_0000) r = 64'h8000_0000_0000_0000;
      else r = 64'd0 - mag[63:0];
    end else begin
      if (mag > 65'h0_7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
      else r = mag[63:0];
    end
    return r;
  endfunction

endpackage

/* src/hnint_ram.sv */
`timescale 1ns / 1ps

module hnint_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/hnint_div.sv */
`timescale 1ns / 1ps
`include "hermite_newton_interpolator_top_defines.svh"

module hnint_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hnint_pkg::DIVD_W-1:0] dividend,
  input  logic [63:0]                 divisor,
  input  logic                        neg,
  output logic                        done,
  output logic [63:0]                 result
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND, D_DONE} dstate_t;

  dstate_t                         state;
  logic [hnint_pkg::STEP_W-1:0]    step;
  logic [hnint_pkg::DIVD_W-1:0]    dq;
  logic [63:0]                     rem;
  logic [63:0]                     dvs;
  logic                            sgn;
  logic [64:0]                     mag;
  logic [64:0]                     trial;
  logic [64:0]                     diff;
  logic                            ge;
  logic                            round_up;
  logic                            qsat;

  assign trial = {rem, dq[hnint_pkg::DIVD_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign diff = trial - {1'b0, dvs};
  assign round_up = {rem, 1'b0} >= {1'b0, dvs};
  assign qsat = |dq[hnint_pkg::DIVD_W-1:63];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            dq <= dividend;
            rem <= '0;
            dvs <= divisor;
            sgn <= neg;
            step <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? diff[63:0] : trial[63:0];
          dq <= {dq[hnint_pkg::DIVD_W-2:0], ge};
          step <= step + 1'b1;
          if (step == hnint_pkg::STEP_W'(hnint_pkg::DIVD_W - 1)) begin
            state <= D_ROUND;
          end
        end
        D_ROUND: begin
          mag <= qsat ? 65'h0_8000_0000_0000_0000 : ({1'b0, dq[63:0]} + 65'(round_up));
          state <= D_DONE;
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign done = state == D_DONE;
  assign result = hnint_pkg::from_mag(mag, sgn);

  `HNINT_IMPLIES(a_start_idle, start, state == D_IDLE, "Divider started while busy.")

endmodule

/* src/hnint_dp.sv */
`timescale 1ns / 1ps

module hnint_dp #(
  parameter int MAX_NODES = hnint_pkg::MAX_NODES_DEF,
  localparam int AW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hnint_pkg::cmd_t        cmd,
  input  logic [AW-1:0]          addr_a,
  input  logic [AW-1:0]          addr_b,
  input  logic [CW-1:0]          lvl,
  input  logic signed [31:0]     in_x,
  input  logic signed [31:0]     in_y,
  input  logic signed [31:0]     in_t,
  output hnint_pkg::status_t     status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic [3:0]             out_index,
  output logic [63:0]            out_value,
  output logic                   out_last
);

  hnint_pkg::op_t op;

  logic signed [31:0] x_reg, y_reg, t_reg, last_x;
  logic [AW-1:0]      last_gs, gs_new;
  logic [31:0]        x_rd, y_rd;
  logic [AW-1:0]      gs_rd;
  logic [63:0]        w_rd, c_rd;
  logic [CW:0]        ysum, ysum_m;
  logic [AW-1:0]      x_raddr, y_raddr, w_raddr;
  logic               x_re, y_re, gs_re, w_re, c_re, w_we, c_we, ld_we;
  logic [63:0]        wdata;

  logic signed [31:0] xa, xb, yv;
  logic [63:0]        wu, wl, fct;
  logic               eq, fz, zf;
  logic [64:0]        du;
  logic [32:0]        dx;
  logic [31:0]        ymag;
  logic [63:0]        dumag;
  logic [32:0]        dxmag;
  logic               div_start, div_neg, div_done;
  logic [hnint_pkg::DIVD_W-1:0] div_dividend;
  logic [63:0]        div_divisor, div_result;

  logic [63:0]        acc, creg, amag, prod;
  logic               eneg;
  logic [32:0]        dreg, dmag;
  logic [64:0]        pa, pb, pmag, mres, pcalc;
  logic [31:0]        mop;
  logic [64:0]        ssum;
  logic [63:0]        sat_sum;
  logic               out_free, push;

  assign op = cmd.op;

  always_comb begin
    ysum = CW'(gs_rd) + ((op == hnint_pkg::OP_LV_RD1) ? {1'b0, lvl} : '0);
    if (ysum >= (CW + 1)'(MAX_NODES)) begin
      ysum_m = ysum - (CW + 1)'(MAX_NODES);
    end else begin
      ysum_m = ysum;
    end
  end
  assign y_raddr = ysum_m[AW-1:0];

  assign ld_we = op == hnint_pkg::OP_LOAD;
  assign gs_new = (cmd.nz && (x_reg == last_x)) ? last_gs : addr_a;
  assign x_raddr = (op == hnint_pkg::OP_LV_RD1) ? addr_b : addr_a;
  assign x_re = (op == hnint_pkg::OP_LV_RD0) || (op == hnint_pkg::OP_LV_RD1)
             || (op == hnint_pkg::OP_EV_RD);
  assign y_re = (op == hnint_pkg::OP_INIT_RY) || (op == hnint_pkg::OP_LV_RD1);
  assign gs_re = (op == hnint_pkg::OP_INIT_RG) || (op == hnint_pkg::OP_LV_RD0);
  assign w_re = (op == hnint_pkg::OP_LV_RD0) || (op == hnint_pkg::OP_LV_RD1);
  assign w_raddr = (op == hnint_pkg::OP_LV_RD0) ? addr_b : addr_a;
  assign c_re = (op == hnint_pkg::OP_EM_RD) || (op == hnint_pkg::OP_EV_TOP)
             || (op == hnint_pkg::OP_EV_RD);
  assign w_we = (op == hnint_pkg::OP_INIT_WR) || (op == hnint_pkg::OP_LV_WR);
  assign c_we = (w_we && cmd.first) || (op == hnint_pkg::OP_ZERO_COEF);

  always_comb begin
    case (op)
      hnint_pkg::OP_INIT_WR: wdata = {{16{y_rd[31]}}, y_rd, 16'd0};
      hnint_pkg::OP_LV_WR:   wdata = zf ? 64'd0 : div_result;
      default:               wdata = 64'd0;
    endcase
  end

  hnint_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_x_ram (
    .clk(clk), .we(ld_we), .waddr(addr_a), .wdata(x_reg),
    .re(x_re), .raddr(x_raddr), .rdata(x_rd)
  );

  hnint_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_y_ram (
    .clk(clk), .we(ld_we), .waddr(addr_a), .wdata(y_reg),
    .re(y_re), .raddr(y_raddr), .rdata(y_rd)
  );

  hnint_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_gs_ram (
    .clk(clk), .we(ld_we), .waddr(addr_a), .wdata(gs_new),
    .re(gs_re), .raddr(addr_a), .rdata(gs_rd)
  );

  hnint_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_work_ram (
    .clk(clk), .we(w_we), .waddr(addr_a), .wdata(wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rd)
  );

  hnint_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_coef_ram (
    .clk(clk), .we(c_we), .waddr(lvl[AW-1:0]), .wdata(wdata),
    .re(c_re), .raddr(addr_a), .rdata(c_rd)
  );

  assign ymag = yv[31] ? (32'd0 - yv) : yv;
  assign dumag = du[64] ? (64'd0 - du[63:0]) : du[63:0];
  assign dxmag = dx[32] ? (33'd0 - dx) : dx;
  assign div_start = op == hnint_pkg::OP_LV_START;
  assign div_dividend = eq ? {32'd0, ymag, 16'd0} : {dumag, 16'd0};
  assign div_divisor = eq ? fct : {31'd0, dxmag};
  assign div_neg = eq ? yv[31] : (du[64] ^ dx[32]);

  hnint_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .neg(div_neg), .done(div_done), .result(div_result)
  );

  assign mop = (op == hnint_pkg::OP_EV_M2) ? amag[63:32] : amag[31:0];
  assign mres = mop * dmag;
  assign pcalc = (pa >= 65'h0_0000_8000_0000_0000) ? 65'h0_8000_0000_0000_0000
               : ((pa << 16) + ((pb + 65'd32768) >> 16));
  assign ssum = {prod[63], prod} + {creg[63], creg};
  assign sat_sum = (ssum[64] != ssum[63])
                 ? (ssum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                 : ssum[63:0];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_reg <= in_x;
      y_reg <= in_y;
      t_reg <= in_t;
    end
    case (op)
      hnint_pkg::OP_LOAD: begin
        last_x <= x_reg;
        last_gs <= gs_new;
      end
      hnint_pkg::OP_LV_RD1: begin
        xa <= x_rd;
        wu <= w_rd;
      end
      hnint_pkg::OP_LV_RD2: begin
        xb <= x_rd;
        wl <= w_rd;
        yv <= y_rd;
      end
      hnint_pkg::OP_LV_PREP: begin
        eq <= xa == xb;
        du <= {wu[63], wu} - {wl[63], wl};
        dx <= {xb[31], xb} - {xa[31], xa};
        fct <= hnint_pkg::fact(8'(lvl));
        fz <= hnint_pkg::fact(8'(lvl)) == 64'd0;
      end
      hnint_pkg::OP_LV_START: begin
        zf <= eq && fz;
      end
      hnint_pkg::OP_EV_LD: begin
        acc <= c_rd;
      end
      hnint_pkg::OP_EV_D: begin
        dreg <= {t_reg[31], t_reg} - {x_rd[31], x_rd};
        creg <= c_rd;
        amag <= acc[63] ? (64'd0 - acc) : acc;
        eneg <= acc[63];
      end
      hnint_pkg::OP_EV_M1: begin
        dmag <= dreg[32] ? (33'd0 - dreg) : dreg;
        eneg <= eneg ^ dreg[32];
      end
      hnint_pkg::OP_EV_M2: begin
        pa <= mres;
      end
      hnint_pkg::OP_EV_M3: begin
        pb <= mres;
      end
      hnint_pkg::OP_EV_ADD: begin
        pmag <= pcalc;
      end
      hnint_pkg::OP_EV_FM: begin
        prod <= hnint_pkg::from_mag(pmag, eneg);
      end
      hnint_pkg::OP_EV_SUM: begin
        acc <= sat_sum;
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign push = out_free && ((op == hnint_pkg::OP_EM_PUSH) || (op == hnint_pkg::OP_PUSH_VAL)
             || (op == hnint_pkg::OP_PUSH_VZERO) || (op == hnint_pkg::OP_PUSH_FULL));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      case (op)
        hnint_pkg::OP_EM_PUSH: begin
          out_kind <= hnint_pkg::KIND_COEF;
          out_index <= cmd.index;
          out_value <= c_rd;
          out_last <= cmd.last;
        end
        hnint_pkg::OP_PUSH_VAL: begin
          out_kind <= hnint_pkg::KIND_VALUE;
          out_index <= 4'd0;
          out_value <= acc;
          out_last <= 1'b1;
        end
        hnint_pkg::OP_PUSH_VZERO: begin
          out_kind <= hnint_pkg::KIND_VALUE;
          out_index <= 4'd0;
          out_value <= 64'd0;
          out_last <= 1'b1;
        end
        default: begin
          out_kind <= hnint_pkg::KIND_FULL;
          out_index <= 4'd0;
          out_value <= 64'd0;
          out_last <= 1'b1;
        end
      endcase
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = out_free;

endmodule

/* src/hnint_ctrl.sv */
`timescale 1ns / 1ps
`include "hermite_newton_interpolator_top_defines.svh"

module hnint_ctrl #(
  parameter int MAX_NODES = hnint_pkg::MAX_NODES_DEF,
  localparam int AW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  hnint_pkg::status_t status,
  output hnint_pkg::cmd_t    cmd,
  output logic [AW-1:0]      addr_a,
  output logic [AW-1:0]      addr_b,
  output logic [CW-1:0]      lvl
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_FULL, S_ZERO, S_INIT_RG, S_INIT_RY, S_INIT_WR,
    S_LV_RD0, S_LV_RD1, S_LV_RD2, S_LV_PREP, S_LV_START, S_LV_DIV, S_LV_WR,
    S_EM_RD, S_EM_PUSH, S_EV_TOP, S_EV_LD, S_EV_RD, S_EV_D, S_EV_M1, S_EV_M2,
    S_EV_M3, S_EV_ADD, S_EV_FM, S_EV_SUM, S_EV_OUT, S_EV_ZERO
  } state_t;

  state_t        state;
  logic [CW-1:0] nc, cnt, i, j;
  logic [CW:0]   nc_ext, cnt_ext, j_inc, i_inc, ji, ji1;
  logic [CW-1:0] cnt_dec, i_dec;
  logic          take;

  assign nc_ext = {1'b0, nc};
  assign cnt_ext = {1'b0, cnt};
  assign j_inc = {1'b0, j} + (CW + 1)'(1);
  assign i_inc = {1'b0, i} + (CW + 1)'(1);
  assign ji = {1'b0, j} + {1'b0, i};
  assign ji1 = ji + (CW + 1)'(1);
  assign cnt_dec = cnt - CW'(1);
  assign i_dec = i - CW'(1);
  assign in_ready = state == S_IDLE;
  assign take = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.op = hnint_pkg::OP_NONE;
    cmd.take = take;
    cmd.first = j == '0;
    cmd.last = j_inc == cnt_ext;
    cmd.nz = nc != '0;
    cmd.index = 4'(j);
    addr_a = j[AW-1:0];
    addr_b = j_inc[AW-1:0];
    lvl = i;
    case (state)
      S_LOAD: begin
        cmd.op = hnint_pkg::OP_LOAD;
        addr_a = nc[AW-1:0];
      end
      S_FULL:     cmd.op = hnint_pkg::OP_PUSH_FULL;
      S_ZERO:     cmd.op = hnint_pkg::OP_ZERO_COEF;
      S_INIT_RG:  cmd.op = hnint_pkg::OP_INIT_RG;
      S_INIT_RY:  cmd.op = hnint_pkg::OP_INIT_RY;
      S_INIT_WR:  cmd.op = hnint_pkg::OP_INIT_WR;
      S_LV_RD0:   cmd.op = hnint_pkg::OP_LV_RD0;
      S_LV_RD1: begin
        cmd.op = hnint_pkg::OP_LV_RD1;
        addr_b = ji[AW-1:0];
      end
      S_LV_RD2:   cmd.op = hnint_pkg::OP_LV_RD2;
      S_LV_PREP:  cmd.op = hnint_pkg::OP_LV_PREP;
      S_LV_START: cmd.op = hnint_pkg::OP_LV_START;
      S_LV_WR:    cmd.op = hnint_pkg::OP_LV_WR;
      S_EM_RD:    cmd.op = hnint_pkg::OP_EM_RD;
      S_EM_PUSH:  cmd.op = hnint_pkg::OP_EM_PUSH;
      S_EV_TOP: begin
        cmd.op = hnint_pkg::OP_EV_TOP;
        addr_a = cnt_dec[AW-1:0];
      end
      S_EV_LD:    cmd.op = hnint_pkg::OP_EV_LD;
      S_EV_RD: begin
        cmd.op = hnint_pkg::OP_EV_RD;
        addr_a = i_dec[AW-1:0];
      end
      S_EV_D:     cmd.op = hnint_pkg::OP_EV_D;
      S_EV_M1:    cmd.op = hnint_pkg::OP_EV_M1;
      S_EV_M2:    cmd.op = hnint_pkg::OP_EV_M2;
      S_EV_M3:    cmd.op = hnint_pkg::OP_EV_M3;
      S_EV_ADD:   cmd.op = hnint_pkg::OP_EV_ADD;
      S_EV_FM:    cmd.op = hnint_pkg::OP_EV_FM;
      S_EV_SUM:   cmd.op = hnint_pkg::OP_EV_SUM;
      S_EV_OUT:   cmd.op = hnint_pkg::OP_PUSH_VAL;
      S_EV_ZERO:  cmd.op = hnint_pkg::OP_PUSH_VZERO;
      default:    cmd.op = hnint_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nc <= '0;
      cnt <= '0;
      i <= '0;
      j <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            case (in_action)
              hnint_pkg::ACT_LOAD: begin
                state <= (nc == CW'(MAX_NODES)) ? S_FULL : S_LOAD;
              end
              hnint_pkg::ACT_COMPUTE: begin
                cnt <= (nc == '0) ? CW'(1) : nc;
                i <= '0;
                j <= '0;
                state <= (nc == '0) ? S_ZERO : S_INIT_RG;
              end
              hnint_pkg::ACT_EVAL: begin
                state <= (cnt == '0) ? S_EV_ZERO : S_EV_TOP;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LOAD: begin
          nc <= nc + CW'(1);
          state <= S_IDLE;
        end
        S_FULL, S_EV_OUT, S_EV_ZERO: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        S_ZERO: begin
          j <= '0;
          state <= S_EM_RD;
        end
        S_INIT_RG: state <= S_INIT_RY;
        S_INIT_RY: state <= S_INIT_WR;
        S_INIT_WR: begin
          if (j_inc < nc_ext) begin
            j <= j + CW'(1);
            state <= S_INIT_RG;
          end else begin
            j <= '0;
            i <= CW'(1);
            state <= (nc_ext > (CW + 1)'(1)) ? S_LV_RD0 : S_EM_RD;
          end
        end
        S_LV_RD0:   state <= S_LV_RD1;
        S_LV_RD1:   state <= S_LV_RD2;
        S_LV_RD2:   state <= S_LV_PREP;
        S_LV_PREP:  state <= S_LV_START;
        S_LV_START: state <= S_LV_DIV;
        S_LV_DIV: begin
          if (status.div_done) begin
            state <= S_LV_WR;
          end
        end
        S_LV_WR: begin
          if (ji1 < nc_ext) begin
            j <= j + CW'(1);
            state <= S_LV_RD0;
          end else if (i_inc < nc_ext) begin
            i <= i + CW'(1);
            j <= '0;
            state <= S_LV_RD0;
          end else begin
            j <= '0;
            state <= S_EM_RD;
          end
        end
        S_EM_RD: state <= S_EM_PUSH;
        S_EM_PUSH: begin
          if (status.out_free) begin
            if (j_inc == cnt_ext) begin
              state <= S_IDLE;
            end else begin
              j <= j + CW'(1);
              state <= S_EM_RD;
            end
          end
        end
        S_EV_TOP: begin
          i <= cnt_dec;
          state <= S_EV_LD;
        end
        S_EV_LD: begin
          state <= (i == '0) ? S_EV_OUT : S_EV_RD;
        end
        S_EV_RD:  state <= S_EV_D;
        S_EV_D:   state <= S_EV_M1;
        S_EV_M1:  state <= S_EV_M2;
        S_EV_M2:  state <= S_EV_M3;
        S_EV_M3:  state <= S_EV_ADD;
        S_EV_ADD: state <= S_EV_FM;
        S_EV_FM:  state <= S_EV_SUM;
        S_EV_SUM: begin
          i <= i_dec;
          state <= (i == CW'(1)) ? S_EV_OUT : S_EV_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HNINT_ALWAYS(a_nc_cap, nc <= CW'(MAX_NODES), "Node count beyond capacity.")
  `HNINT_IMPLIES(a_span, state == S_LV_WR, ji < nc_ext, "Table span beyond node count.")
  `HNINT_IMPLIES(a_emit, state == S_EM_PUSH, j_inc <= cnt_ext, "Coefficient beyond count.")

endmodule

/* src/hermite_newton_interpolator_top.sv */
// Load: no result; a load into a full store gives a full-kind beat instead.
// Compute: the table for n nodes is built with one bit-serial divider.
// The divider holds the sequencer for each table entry until it is done; coefficients leave one
// at a time, each held until the output is free.
// Evaluate: m coefficients are combined with one shared 32x33 multiplier.
// Synchronous active-high reset clears node and coefficient counts; stores need no clearing.
`timescale 1ns / 1ps

module hermite_newton_interpolator_top #(
  parameter int MAX_NODES = hnint_pkg::MAX_NODES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // node_x, node_y, point_t
  input  logic [1:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // index, value, zero padding
  output logic [1:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  hnint_pkg::cmd_t    cmd;
  hnint_pkg::status_t status;
  logic [AW-1:0]      addr_a, addr_b;
  logic [CW-1:0]      lvl;
  logic [3:0]         out_index;
  logic [63:0]        out_value;

  hnint_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_action(s_axis_tuser), .status(status), .cmd(cmd),
    .addr_a(addr_a), .addr_b(addr_b), .lvl(lvl)
  );

  hnint_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .addr_a(addr_a), .addr_b(addr_b), .lvl(lvl),
    .in_x(s_axis_tdata[31:0]), .in_y(s_axis_tdata[63:32]), .in_t(s_axis_tdata[95:64]),
    .status(status), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_kind(m_axis_tuser), .out_index(out_index), .out_value(out_value),
    .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_value, out_index};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 262;
  localparam int FULL_COMPUTES = 4;
  localparam longint CYCLE_LIMIT = 15000000;
  localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Q_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  index;
    logic [63:0] value;
    logic        last;
  } interp_beat_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
    logic        typed;
  } stim_row_t;

  localparam int N_DIRECTED = 18;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{hnint_pkg::ACT_EVAL,    32'h0,        32'h0,        32'h7FFF_FFFF, 1'b1},
    '{hnint_pkg::ACT_COMPUTE, 32'h0,        32'h0,        32'h0,         1'b1},
    '{ACT_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{hnint_pkg::ACT_EVAL,    32'h0,        32'h0,        32'h0,         1'b1},
    '{hnint_pkg::ACT_LOAD,    32'h8000_0000, 32'h7FFF_FFFF, 32'h0,       1'b0},
    '{hnint_pkg::ACT_LOAD,    32'h8000_0000, 32'h8000_0000, 32'h0,       1'b0},
    '{hnint_pkg::ACT_LOAD,    32'h8000_0000, 32'h0001_0000, 32'h0,       1'b0},
    '{hnint_pkg::ACT_LOAD,    32'h7FFF_FFFF, 32'h8000_0000, 32'h0,       1'b0},
    '{hnint_pkg::ACT_LOAD,    32'h0,        32'hFFFF_FFFF, 32'h0,        1'b0},
    '{hnint_pkg::ACT_COMPUTE, 32'h0,        32'h0,        32'h0,         1'b0},
    '{hnint_pkg::ACT_EVAL,    32'h0,        32'h0,        32'h8000_0000, 1'b0},
    '{hnint_pkg::ACT_EVAL,    32'h0,        32'h0,        32'h7FFF_FFFF, 1'b0},
    '{hnint_pkg::ACT_EVAL,    32'h0,        32'h0,        32'h0,         1'b0},
    '{hnint_pkg::ACT_LOAD,    32'h8000_0000, 32'h1234_5678, 32'h0,       1'b0},
    '{hnint_pkg::ACT_LOAD,    32'h0001_0000, 32'h0002_0000, 32'h0,       1'b0},
    '{hnint_pkg::ACT_COMPUTE, 32'h0,        32'h0,        32'h0,         1'b0},
    '{hnint_pkg::ACT_EVAL,    32'h0,        32'h0,        32'h0000_8000, 1'b0},
    '{hnint_pkg::ACT_EVAL,    32'h0,        32'h0,        32'hFFFF_0000, 1'b0}
  };

  localparam logic [63:0] FACTORIALS [0:20] = '{
    64'd1, 64'd1, 64'd2, 64'd6, 64'd24, 64'd120, 64'd720, 64'd5040, 64'd40320,
    64'd362880, 64'd3628800, 64'd39916800, 64'd479001600, 64'd6227020800,
    64'd87178291200, 64'd1307674368000, 64'd20922789888000,
    64'd355687428096000, 64'd6402373705728000, 64'd121645100408832000,
    64'd2432902008176640000
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  hermite_newton_interpolator_top DUT (.*);

  logic signed [31:0] node_x_mem [STORE_DEPTH];
  logic signed [31:0] node_y_mem [STORE_DEPTH];
  int unsigned        group_mem  [STORE_DEPTH];
  longint             diff_mem   [STORE_DEPTH];
  longint             coef_mem   [STORE_DEPTH];
  int unsigned        nodes_held = 0;
  int unsigned        coefs_held = 0;

  interp_beat_t pending_beats [$];
  interp_beat_t fresh_beats [$];
  int  errors = 0;
  int  beats_checked = 0;
  int  n_loads = 0, n_rejects = 0, n_computes = 0, n_evals = 0;
  longint cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'd0 - v : v;
  endfunction

  function automatic longint signed_sat(input logic [63:0] mag, input bit neg);
    if (neg) return mag[63] ? Q_MIN : longint'(64'd0 - mag);
    return mag[63] ? Q_MAX : longint'(mag);
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    if (b > 0 && a > Q_MAX - b) return Q_MAX;
    if (b < 0 && a < Q_MIN - b) return Q_MIN;
    return a + b;
  endfunction

  function automatic longint derivative_term(input logic signed [31:0] y, input int unsigned k);
    longint v;
    logic [63:0] m, f, q, r;
    v = longint'(y) * 65536;
    m = magnitude(v);
    if (k > 20) return 0;
    f = FACTORIALS[k];
    q = m / f;
    r = m % f;
    if (r >= f - r) q = q + 1;
    return signed_sat(q, v < 0);
  endfunction

  function automatic longint divided_step(input longint up, input longint lo, input longint dx);
    logic [63:0] num, den, q1, r, t, q2, r2, res;
    bit neg;
    den = magnitude(dx);
    if (up >= lo) begin
      num = up - lo;
      neg = 0;
    end else begin
      num = lo - up;
      neg = 1;
    end
    if (dx < 0) neg = !neg;
    if (den == 0) return 0;
    q1 = num / den;
    r = num % den;
    if (q1 >= 64'h8000_0000_0000) return signed_sat(64'h8000_0000_0000_0000, neg);
    t = r << 16;
    q2 = t / den;
    r2 = t % den;
    res = (q1 << 16) + q2;
    if (r2 * 2 >= den) res = res + 1;
    return signed_sat(res, neg);
  endfunction

  function automatic longint scale_by_offset(input longint acc, input longint d);
    logic [63:0] mr, md, hi, lo, a, b, res;
    bit neg;
    mr = magnitude(acc);
    md = magnitude(d);
    neg = (acc < 0) != (d < 0);
    hi = mr >> 32;
    lo = mr & 64'hFFFF_FFFF;
    a = hi * md;
    b = lo * md;
    if (a >= 64'h8000_0000_0000) return signed_sat(64'h8000_0000_0000_0000, neg);
    res = (a << 16) + ((b + 64'd32768) >> 16);
    return signed_sat(res, neg);
  endfunction

  task automatic build_newton_form();
    int unsigned n;
    n = nodes_held;
    for (int j = 0; j < n; j++) diff_mem[j] = longint'(node_y_mem[group_mem[j] % 16]) * 65536;
    coef_mem[0] = n != 0 ? diff_mem[0] : 0;
    for (int i = 1; i < n; i++) begin
      for (int j = 0; j + i < n; j++) begin
        if (node_x_mem[j] == node_x_mem[j + i])
          diff_mem[j] = derivative_term(node_y_mem[(group_mem[j] + i) % 16], i);
        else
          diff_mem[j] = divided_step(diff_mem[j + 1], diff_mem[j],
              longint'(node_x_mem[j + i]) - longint'(node_x_mem[j]));
      end
      coef_mem[i] = diff_mem[0];
    end
    coefs_held = n != 0 ? n : 1;
  endtask

  function automatic longint horner_value(input logic signed [31:0] t);
    longint acc;
    if (coefs_held == 0) return 0;
    acc = coef_mem[coefs_held - 1];
    for (int i = coefs_held - 1; i > 0; i--)
      acc = add_sat(scale_by_offset(acc, longint'(t) - longint'(node_x_mem[i - 1])),
                    coef_mem[i - 1]);
    return acc;
  endfunction

  task automatic predict_interp(input logic [1:0] action, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] t);
    fresh_beats.delete();
    case (action)
      hnint_pkg::ACT_LOAD: begin
        if (nodes_held >= STORE_DEPTH) begin
          fresh_beats.push_back('{hnint_pkg::KIND_FULL, 4'd0, 64'd0, 1'b1});
          n_rejects++;
        end else begin
          node_x_mem[nodes_held] = x;
          node_y_mem[nodes_held] = y;
          if (nodes_held > 0 && node_x_mem[nodes_held - 1] == x)
            group_mem[nodes_held] = group_mem[nodes_held - 1];
          else
            group_mem[nodes_held] = nodes_held;
          nodes_held++;
          n_loads++;
        end
      end
      hnint_pkg::ACT_COMPUTE: begin
        build_newton_form();
        for (int k = 0; k < coefs_held; k++)
          fresh_beats.push_back('{hnint_pkg::KIND_COEF, 4'(k), coef_mem[k],
                                  k + 1 == coefs_held});
        n_computes++;
      end
      hnint_pkg::ACT_EVAL: begin
        fresh_beats.push_back('{hnint_pkg::KIND_VALUE, 4'd0, horner_value(t), 1'b1});
        n_evals++;
      end
      default: ;
    endcase
  endtask

  int burst_left = 0;

  task automatic send_item(input logic [1:0] action, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] t, input bit typed);
    int gap;
    s_axis_tuser <= action;
    s_axis_tdata <= {t, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_interp(action, x, y, t);
    foreach (fresh_beats[i]) begin
      if (typed) pending_beats.push_back('{fresh_beats[i].kind, 4'd0, 64'd0, 1'b1});
      else pending_beats.push_back(fresh_beats[i]);
    end
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
  endtask

  int stall_mode = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_phase % 4 == 0);
      default: m_axis_tready <= (stall_phase % 32) > 20;
    endcase
  end

  always @(posedge clk) begin
    interp_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: kind %0d value %h", m_axis_tuser, m_axis_tdata[67:4]);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[3:0] !== want.index) begin
          $error("index: expected %0d, actual %0d", want.index, m_axis_tdata[3:0]);
          errors++;
        end
        if (m_axis_tdata[67:4] !== want.value) begin
          $error("value: expected %h, actual %h", want.value, m_axis_tdata[67:4]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [1:0]  act;
    logic [31:0] x, y, t;
    int full_computes;
    int pick;
    full_computes = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++)
      send_item(DIRECTED[r].action, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].t,
                DIRECTED[r].typed);

    for (int r = 0; r < RANDOM_ITEMS; r++) begin
      pick = $urandom_range(0, 99);
      x = $urandom;
      y = $urandom;
      t = $urandom;
      if ($urandom_range(0, 2) == 0) x = 32'($urandom_range(0, 8) << 15) - 32'h0002_0000;
      if ($urandom_range(0, 2) == 0) t = 32'($urandom_range(0, 16) << 14) - 32'h0002_0000;
      if (nodes_held < STORE_DEPTH) begin
        if (pick < 55) act = hnint_pkg::ACT_LOAD;
        else if (pick < 75) act = hnint_pkg::ACT_COMPUTE;
        else if (pick < 97) act = hnint_pkg::ACT_EVAL;
        else act = ACT_UNUSED;
        if (act == hnint_pkg::ACT_LOAD && nodes_held > 0 && $urandom_range(0, 2) == 0)
          x = node_x_mem[nodes_held - 1];
      end else begin
        if (pick < 30) act = hnint_pkg::ACT_LOAD;
        else if (pick < 33 && full_computes < FULL_COMPUTES) act = hnint_pkg::ACT_COMPUTE;
        else if (pick < 97) act = hnint_pkg::ACT_EVAL;
        else act = ACT_UNUSED;
        if (act == hnint_pkg::ACT_COMPUTE) full_computes++;
      end
      send_item(act, x, y, t, 1'b0);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d node loads, %0d rejected loads, %0d computes, %0d evaluations.",
             n_loads, n_rejects, n_computes, n_evals);
    $display("Checked %0d result beats under random source gaps and sink stalls.",
             beats_checked);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
